/* design/sliding_trimmed_mean_filter_macros.svh */
// assertion macros for the sliding trimmed mean filter
// expects clk and rst_n in the scope of each use
`ifndef SLIDING_TRIMMED_MEAN_FILTER_MACROS_SVH
`define SLIDING_TRIMMED_MEAN_FILTER_MACROS_SVH

// same-cycle implication, reported by label
`define STMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reported by label
`define STMF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/stmf_pkg.sv */
// shared types and constants of the sliding trimmed mean filter
// no dependencies
`timescale 1ns / 1ps

package stmf_pkg;

  localparam int DATA_W        = 32;
  localparam int NCH           = 3;   // channels per history memory
  localparam int DEF_WIN_DEPTH = 8;
  localparam int DEF_AE_DEPTH  = 4;

  localparam logic REQ_SHIFT = 1'b0;
  localparam logic REQ_FILL  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] focus_a;
    logic [DATA_W-1:0] focus_b;
    logic [DATA_W-1:0] focus_c;
    logic [DATA_W-1:0] shutter;
    logic [DATA_W-1:0] sensor_gain;
    logic [DATA_W-1:0] isp_gain;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] mean_focus_a;
    logic [DATA_W-1:0] mean_focus_b;
    logic [DATA_W-1:0] mean_focus_c;
    logic [DATA_W-1:0] mean_shutter;
    logic [DATA_W-1:0] mean_sensor_gain;
    logic [DATA_W-1:0] mean_isp_gain;
  } out_item_t;

endpackage

/* design/stmf_in_if.sv */
// valid/ready channel carrying one input item
// depends on stmf_pkg
`timescale 1ns / 1ps

interface stmf_in_if import stmf_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/stmf_out_if.sv */
// valid/ready channel carrying one result item
// depends on stmf_pkg
`timescale 1ns / 1ps

interface stmf_out_if import stmf_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/sliding_trimmed_mean_filter.sv */
// sliding window trimmed mean over three focus and three exposure channels
// depends on stmf_pkg, stmf_in_if, stmf_out_if and the assertion macros
//
//   channel   dir   handshake            payload
//   in_ch     in    valid / ready        in_item_t: request type and six samples
//   out_ch    out   valid / ready        out_item_t: six trimmed means
//
// shift item, in order: write, one read per row through each memory's read port, drain,
// subtract, divide (two 16-bit quotient digits by reciprocal multiply) and the output load
// fill item: the values go straight through the quotient registers to the output load
// either way the block is ready for the next item in the cycle after the output load;
// reset clears the valid bits at once, no clearing pass
// a stalled result waits in the output register while the next item is taken
`timescale 1ns / 1ps
`include "sliding_trimmed_mean_filter_macros.svh"

module sliding_trimmed_mean_filter import stmf_pkg::*; #(
  parameter int WIN_DEPTH = DEF_WIN_DEPTH,
  parameter int AE_DEPTH  = DEF_AE_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  stmf_in_if.sink    in_ch,
  stmf_out_if.source out_ch
);

  // derived sizes
  localparam int MAXD  = (WIN_DEPTH > AE_DEPTH) ? WIN_DEPTH : AE_DEPTH;
  localparam int CW    = $clog2(MAXD);
  localparam int FAW   = $clog2(WIN_DEPTH);
  localparam int EAW   = $clog2(AE_DEPTH);
  localparam int SUM_W = DATA_W + CW;
  localparam int RW    = CW;            // divide remainder stays below depth - 2
  localparam int ROW_W = NCH * DATA_W;
  localparam int NALL  = 2 * NCH;

  localparam logic [RW:0] DIV_F = (RW+1)'(WIN_DEPTH - 2);
  localparam logic [RW:0] DIV_E = (RW+1)'(AE_DEPTH - 2);

  // divide by a constant: two quotient digits, each from a partial dividend
  // below divisor * 2^DIG_W, by multiplying with a rounded-up reciprocal
  localparam int DIG_W = DATA_W / 2;
  localparam int YW    = RW + DIG_W;    // partial dividend width
  localparam int PW    = 2 * YW + 1;    // reciprocal product width
  localparam int DF    = WIN_DEPTH - 2;
  localparam int DE    = AE_DEPTH - 2;
  localparam int SH_F  = YW + $clog2(DF);
  localparam int SH_E  = YW + $clog2(DE);
  localparam logic [YW:0] MUL_F =
    (YW+1)'(((64'd1 << SH_F) + 64'(DF) - 64'd1) / 64'(DF));
  localparam logic [YW:0] MUL_E =
    (YW+1)'(((64'd1 << SH_E) + 64'(DE) - 64'd1) / 64'(DE));

  localparam logic [1:0] DIV_LAST = 2'd3;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR   = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_PREP = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0] div_cnt_r, div_cnt_nxt;

  // history memories, one row holds the three channels of one frame
  logic [ROW_W-1:0] mem_f [WIN_DEPTH];
  logic [ROW_W-1:0] mem_e [AE_DEPTH];
  logic [WIN_DEPTH-1:0] vf_r;          // row written since the last fill
  logic [AE_DEPTH-1:0]  ve_r;
  logic [FAW-1:0] wp_f_r;              // oldest row, next to be overwritten
  logic [EAW-1:0] wp_e_r;
  logic [DATA_W-1:0] fill_r [NALL];    // value seen by rows not yet written

  logic [ROW_W-1:0] rdf_r, rde_r;      // registered read data
  logic rvf_r, rve_r;                  // valid bit of the row read
  logic accf_r, ace_r;                 // read data present this cycle

  in_item_t in_r;

  // per channel accumulators and divider, focus channels first
  logic [SUM_W-1:0]  sum_r [NALL];
  logic [DATA_W-1:0] min_r [NALL];
  logic [DATA_W-1:0] max_r [NALL];
  logic [YW-1:0]     y_r   [NALL];     // partial dividend, remainder on top
  logic [DIG_W-1:0]  qd_r  [NALL];     // quotient digit
  logic [DATA_W-1:0] q_r   [NALL];

  logic out_valid_r;
  out_item_t out_data_r;

  logic in_acc, out_load, rd_f_en, rd_e_en, wr_e_en;
  logic [DATA_W-1:0] in_vals [NALL];
  logic [DATA_W-1:0] vals [NALL];
  logic [SUM_W-1:0]  diff [NALL];
  logic [PW-1:0]     prod [NALL];
  logic [DIG_W-1:0]  qdig [NALL];
  logic [YW-1:0]     rest [NALL];
  logic [RW:0]       dv [NALL];
  logic [ROW_W-1:0]  row_f, row_e;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign in_vals[0] = in_ch.data.focus_a;
  assign in_vals[1] = in_ch.data.focus_b;
  assign in_vals[2] = in_ch.data.focus_c;
  assign in_vals[3] = in_ch.data.shutter;
  assign in_vals[4] = in_ch.data.sensor_gain;
  assign in_vals[5] = in_ch.data.isp_gain;

  assign row_f = {in_r.focus_c, in_r.focus_b, in_r.focus_a};
  assign row_e = {in_r.isp_gain, in_r.sensor_gain, in_r.shutter};

  // zero shutter leaves the exposure history alone
  assign wr_e_en = (state_r == S_WR) && (in_r.shutter != '0);

  // the read walk covers both memories in step, the shorter one stops early
  assign rd_f_en = (state_r == S_RD) && ({1'b0, cnt_r} < (CW+1)'(WIN_DEPTH));
  assign rd_e_en = (state_r == S_RD) && ({1'b0, cnt_r} < (CW+1)'(AE_DEPTH));

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    div_cnt_nxt = div_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.data.req_type == REQ_FILL) ? S_OUT : S_WR;
        end
      end
      S_WR: begin
        cnt_nxt   = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (cnt_r == CW'(MAXD - 1)) begin
          state_nxt = S_LAST;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_LAST: state_nxt = S_PREP;
      S_PREP: begin
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        div_cnt_nxt = div_cnt_r + 2'd1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // memory ports: one write and one registered read per memory
  always_ff @(posedge clk) begin
    if (state_r == S_WR) begin
      mem_f[wp_f_r] <= row_f;
    end
    if (rd_f_en) begin
      rdf_r <= mem_f[cnt_r[FAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_e_en) begin
      mem_e[wp_e_r] <= row_e;
    end
    if (rd_e_en) begin
      rde_r <= mem_e[cnt_r[EAW-1:0]];
    end
  end

  // valid bits, write pointers and fill values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r   <= '0;
      ve_r   <= '0;
      wp_f_r <= '0;
      wp_e_r <= '0;
      accf_r <= 1'b0;
      ace_r  <= 1'b0;
      rvf_r  <= 1'b0;
      rve_r  <= 1'b0;
      for (int c = 0; c < NALL; c++) begin
        fill_r[c] <= '0;
      end
    end else begin
      accf_r <= rd_f_en;
      ace_r  <= rd_e_en;
      if (rd_f_en) begin
        rvf_r <= vf_r[cnt_r[FAW-1:0]];
      end
      if (rd_e_en) begin
        rve_r <= ve_r[cnt_r[EAW-1:0]];
      end
      if (in_acc && (in_ch.data.req_type == REQ_FILL)) begin
        // every row now reads as the fill value
        vf_r <= '0;
        ve_r <= '0;
        for (int c = 0; c < NALL; c++) begin
          fill_r[c] <= in_vals[c];
        end
      end
      if (state_r == S_WR) begin
        vf_r[wp_f_r] <= 1'b1;
        wp_f_r <= (wp_f_r == FAW'(WIN_DEPTH - 1)) ? '0 : wp_f_r + FAW'(1);
      end
      if (wr_e_en) begin
        ve_r[wp_e_r] <= 1'b1;
        wp_e_r <= (wp_e_r == EAW'(AE_DEPTH - 1)) ? '0 : wp_e_r + EAW'(1);
      end
    end
  end

  // datapath lanes: row value, trimmed difference, quotient digit, remainder
  always_comb begin
    for (int c = 0; c < NALL; c++) begin
      if (c < NCH) begin
        vals[c] = rvf_r ? rdf_r[c*DATA_W +: DATA_W] : fill_r[c];
        dv[c]   = DIV_F;
        prod[c] = PW'(y_r[c]) * PW'(MUL_F);
        qdig[c] = prod[c][SH_F +: DIG_W];
      end else begin
        vals[c] = rve_r ? rde_r[(c-NCH)*DATA_W +: DATA_W] : fill_r[c];
        dv[c]   = DIV_E;
        prod[c] = PW'(y_r[c]) * PW'(MUL_E);
        qdig[c] = prod[c][SH_E +: DIG_W];
      end
      diff[c] = sum_r[c] - SUM_W'(min_r[c]) - SUM_W'(max_r[c]);
      rest[c] = y_r[c] - YW'(qd_r[c]) * YW'(dv[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_ch.data;
    end
    for (int c = 0; c < NALL; c++) begin
      case (state_r)
        S_IDLE: begin
          // a fill item echoes its values through the quotient registers
          if (in_acc) begin
            q_r[c] <= in_vals[c];
          end
        end
        S_WR: begin
          sum_r[c] <= '0;
          min_r[c] <= '1;
          max_r[c] <= '0;
        end
        S_RD, S_LAST: begin
          if ((c < NCH) ? accf_r : ace_r) begin
            sum_r[c] <= sum_r[c] + SUM_W'(vals[c]);
            if (vals[c] < min_r[c]) min_r[c] <= vals[c];
            if (vals[c] > max_r[c]) max_r[c] <= vals[c];
          end
        end
        S_PREP: begin
          // the quotient fits 32 bits, so the top part starts below divisor * 2^16
          y_r[c] <= diff[c][SUM_W-1:DIG_W];
          q_r[c] <= diff[c][DATA_W-1:0];
        end
        S_DIV: begin
          if (!div_cnt_r[0]) begin
            // digit of the current partial dividend
            qd_r[c] <= qdig[c];
          end else if (!div_cnt_r[1]) begin
            // high digit done: its remainder goes on top of the low half
            y_r[c] <= {rest[c][RW-1:0], q_r[c][DIG_W-1:0]};
            q_r[c][DATA_W-1:DIG_W] <= qd_r[c];
          end else begin
            q_r[c][DIG_W-1:0] <= qd_r[c];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.mean_focus_a     <= q_r[0];
      out_data_r.mean_focus_b     <= q_r[1];
      out_data_r.mean_focus_c     <= q_r[2];
      out_data_r.mean_shutter     <= q_r[3];
      out_data_r.mean_sensor_gain <= q_r[4];
      out_data_r.mean_isp_gain    <= q_r[5];
    end
  end

  // checks
  `STMF_ASSERT_IMP(a_rem_focus, state_r == S_DIV, {1'b0, y_r[0][YW-1:DIG_W]} < DIV_F, "focus remainder not below divisor")
  `STMF_ASSERT_IMP(a_rem_expo, state_r == S_DIV, {1'b0, y_r[3][YW-1:DIG_W]} < DIV_E, "exposure remainder not below divisor")
  `STMF_ASSERT_NXT(a_div_done, (state_r == S_DIV) && (div_cnt_r == DIV_LAST), state_r == S_OUT, "divide did not finish after four steps")
  `STMF_ASSERT_NXT(a_shift_wr, in_acc && (in_ch.data.req_type == REQ_SHIFT), state_r == S_WR, "shift item did not start with a write")
  `STMF_ASSERT_IMP(a_out_src, $rose(out_valid_r), $past(state_r) == S_OUT, "result appeared outside the output state")

endmodule

/* tb/stmf_mean_checker.sv */
// predicts and checks the six trimmed means of the sliding filter
// depends on stmf_pkg; watches both channels from beside the block
`timescale 1ns / 1ps

module stmf_mean_checker import stmf_pkg::*; #(
  parameter int WIN_DEPTH = DEF_WIN_DEPTH,
  parameter int AE_DEPTH  = DEF_AE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        means_due,
  output int        means_checked
);

  localparam int NCHAN = 2 * NCH;
  localparam int MAXD  = (WIN_DEPTH > AE_DEPTH) ? WIN_DEPTH : AE_DEPTH;

  // focus channels first, then shutter, sensor gain, isp gain
  logic [DATA_W-1:0] history [NCHAN][MAXD];
  out_item_t         expected_means [$];

  function automatic int depth_of(input int ch);
    return (ch < NCH) ? WIN_DEPTH : AE_DEPTH;
  endfunction

  // exact sum, drop one minimum and one maximum, truncating divide
  function automatic logic [DATA_W-1:0] trimmed_avg(input int ch);
    logic [DATA_W+7:0] total;
    logic [DATA_W+7:0] quot;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    int                d;
    d     = depth_of(ch);
    total = '0;
    lo    = history[ch][0];
    hi    = history[ch][0];
    for (int k = 0; k < d; k++) begin
      total += history[ch][k];
      if (history[ch][k] < lo) lo = history[ch][k];
      if (history[ch][k] > hi) hi = history[ch][k];
    end
    total = total - lo - hi;
    quot  = total / (d - 2);
    return quot[DATA_W-1:0];
  endfunction

  function automatic out_item_t predict_means(input in_item_t f);
    logic [DATA_W-1:0] sample [NCHAN];
    logic [DATA_W-1:0] avg [NCHAN];
    out_item_t         r;
    int                d;
    sample[0] = f.focus_a;
    sample[1] = f.focus_b;
    sample[2] = f.focus_c;
    sample[3] = f.shutter;
    sample[4] = f.sensor_gain;
    sample[5] = f.isp_gain;
    if (f.req_type == REQ_FILL) begin
      for (int ch = 0; ch < NCHAN; ch++) begin
        for (int k = 0; k < MAXD; k++) history[ch][k] = sample[ch];
        avg[ch] = sample[ch];
      end
    end else begin
      for (int ch = 0; ch < NCHAN; ch++) begin
        // exposure rows only move on a nonzero shutter
        if (ch < NCH || f.shutter != '0) begin
          d = depth_of(ch);
          for (int k = 0; k + 1 < d; k++) history[ch][k] = history[ch][k+1];
          history[ch][d-1] = sample[ch];
        end
      end
      for (int ch = 0; ch < NCHAN; ch++) avg[ch] = trimmed_avg(ch);
    end
    r.mean_focus_a     = avg[0];
    r.mean_focus_b     = avg[1];
    r.mean_focus_c     = avg[2];
    r.mean_shutter     = avg[3];
    r.mean_sensor_gain = avg[4];
    r.mean_isp_gain    = avg[5];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < NCHAN; ch++)
        for (int k = 0; k < MAXD; k++) history[ch][k] = '0;
      expected_means.delete();
      mismatches    = 0;
      means_checked = 0;
    end else begin
      if (in_valid === 1'b1 && in_ready === 1'b1)
        expected_means.push_back(predict_means(in_data));
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_means.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual %h", $time, out_data);
        end else begin
          out_item_t want;
          want = expected_means.pop_front();
          check_field("mean_focus_a", want.mean_focus_a, out_data.mean_focus_a);
          check_field("mean_focus_b", want.mean_focus_b, out_data.mean_focus_b);
          check_field("mean_focus_c", want.mean_focus_c, out_data.mean_focus_c);
          check_field("mean_shutter", want.mean_shutter, out_data.mean_shutter);
          check_field("mean_sensor_gain", want.mean_sensor_gain,
                      out_data.mean_sensor_gain);
          check_field("mean_isp_gain", want.mean_isp_gain, out_data.mean_isp_gain);
          means_checked++;
        end
      end
    end
    means_due <= expected_means.size();
  end

endmodule

/* tb/testbench.sv */
// top of the sliding trimmed mean filter testbench: clock, reset, stimulus, verdict
// depends on stmf_pkg, both channel interfaces, the block and stmf_mean_checker
`timescale 1ns / 1ps

module testbench;
  import stmf_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 11;
  // slowest shift item: larger depth plus write, drain, subtract, divide and output steps
  localparam int SETTLE        = ((DEF_WIN_DEPTH > DEF_AE_DEPTH) ? DEF_WIN_DEPTH
                                                                 : DEF_AE_DEPTH) + 9;
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int PHASE_FRAMES  = 110;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;
  localparam logic [DATA_W-1:0] MSB_ONLY = {1'b1, {(DATA_W-1){1'b0}}};

  logic clk;
  logic rst_n;

  stmf_in_if  frame_ch ();
  stmf_out_if mean_ch ();

  int idle_pct;        // chance in percent that the sender skips a cycle
  int stall_pct;       // chance in percent that the receiver holds ready low
  int cycles;
  int frames_sent;
  int fills_sent;
  int zero_shutters;
  int mismatches;
  int means_due;
  int means_checked;

  sliding_trimmed_mean_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (frame_ch),
    .out_ch (mean_ch)
  );

  stmf_mean_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (frame_ch.valid),
    .in_ready      (frame_ch.ready),
    .in_data       (frame_ch.data),
    .out_valid     (mean_ch.valid),
    .out_ready     (mean_ch.ready),
    .out_data      (mean_ch.data),
    .mismatches    (mismatches),
    .means_due     (means_due),
    .means_checked (means_checked)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still due",
               $time, cycles, means_due);
      $display("** sliding_trimmed_mean_filter: FAILED **");
      $finish;
    end
  end

  // receiver: ready rolled fresh every cycle against the current stall chance
  always @(posedge clk) begin
    mean_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // half extremes and small values so min/max trimming gets exercised, half full-range random
  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALL_ONES;
      2, 3:    return $urandom_range(255);
      4:       return ALL_ONES - $urandom_range(255);
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t random_frame();
    in_item_t f;
    f.req_type    = ($urandom_range(99) < 8) ? REQ_FILL : REQ_SHIFT;
    f.focus_a     = pick_sample();
    f.focus_b     = pick_sample();
    f.focus_c     = pick_sample();
    // zero shutter in about a quarter of frames: exposure rows hold still
    f.shutter     = ($urandom_range(3) == 0) ? '0 : pick_sample();
    f.sensor_gain = pick_sample();
    f.isp_gain    = pick_sample();
    return f;
  endfunction

  function automatic in_item_t make_frame(input logic req,
                                          input logic [DATA_W-1:0] fa, fb, fc,
                                          input logic [DATA_W-1:0] sh, sg, ig);
    in_item_t f;
    f.req_type    = req;
    f.focus_a     = fa;
    f.focus_b     = fb;
    f.focus_c     = fc;
    f.shutter     = sh;
    f.sensor_gain = sg;
    f.isp_gain    = ig;
    return f;
  endfunction

  // idle gaps first, then hold valid until the block takes the item
  task automatic send_frame(input in_item_t f);
    while ($urandom_range(99) < idle_pct) begin
      frame_ch.valid <= 1'b0;
      frame_ch.data  <= random_frame();
      @(posedge clk);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.data  <= f;
    @(posedge clk);
    while (frame_ch.ready !== 1'b1) @(posedge clk);
    frames_sent++;
    if (f.req_type == REQ_FILL) fills_sent++;
    else if (f.shutter == '0) zero_shutters++;
  endtask

  // sender holds off until every predicted result has been seen
  task automatic wait_drained();
    frame_ch.valid <= 1'b0;
    @(posedge clk);
    while (means_due != 0) @(posedge clk);
  endtask

  task automatic set_pressure(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct <= stall;
  endtask

  initial begin
    rst_n          = 1'b0;
    frame_ch.valid = 1'b0;
    frame_ch.data  = '0;
    mean_ch.ready  = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling
    // zero history straight out of reset
    send_frame(make_frame(REQ_SHIFT, '0, '0, '0, '0, '0, '0));
    send_frame(make_frame(REQ_SHIFT, 1, 2, 3, 5, 6, 7));
    // fill at the top of the range, then shift more of the same: widest sums
    send_frame(make_frame(REQ_FILL, ALL_ONES, ALL_ONES, ALL_ONES,
                          ALL_ONES, ALL_ONES, ALL_ONES));
    send_frame(make_frame(REQ_SHIFT, ALL_ONES, ALL_ONES, ALL_ONES,
                          ALL_ONES, ALL_ONES, ALL_ONES));
    // zero shutter on a shift: only focus rows take the zeros
    send_frame(make_frame(REQ_SHIFT, '0, '0, '0, '0, '0, '0));
    // fill with zero shutter still loads the exposure rows
    send_frame(make_frame(REQ_FILL, 10, 20, 30, '0, 40, 50));
    send_frame(make_frame(REQ_SHIFT, 100, 200, 300, '0, ALL_ONES, ALL_ONES));
    send_frame(make_frame(REQ_SHIFT, 7, 8, 9, 1, 60, 70));
    // one lone maximum among zeros gets trimmed away
    send_frame(make_frame(REQ_FILL, '0, '0, '0, '0, '0, '0));
    send_frame(make_frame(REQ_SHIFT, ALL_ONES, ALL_ONES, ALL_ONES,
                          ALL_ONES, ALL_ONES, ALL_ONES));
    // alternating extremes across a full window
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0)
        send_frame(make_frame(REQ_SHIFT, ALL_ONES, '0, MSB_ONLY,
                              ALL_ONES, '0, MSB_ONLY));
      else
        send_frame(make_frame(REQ_SHIFT, '0, ALL_ONES, ~MSB_ONLY,
                              1, ALL_ONES, ~MSB_ONLY));
    end
    send_frame(make_frame(REQ_FILL, MSB_ONLY, ~MSB_ONLY, 32'hAAAA_AAAA,
                          32'h5555_5555, MSB_ONLY, ~MSB_ONLY));
    send_frame(make_frame(REQ_SHIFT, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    send_frame(make_frame(REQ_SHIFT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    wait_drained();

    // random phases, each with its own idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_pressure(0, 0);
        1:       set_pressure(83, 0);
        2:       set_pressure(0, 83);
        default: set_pressure(31, 31);
      endcase
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        send_frame(random_frame());
        // one mid-phase hold-off with the pipe emptied out
        if (ph == 1 && n == PHASE_FRAMES / 2) wait_drained();
      end
      wait_drained();
    end

    set_pressure(0, 0);
    repeat (2 * SETTLE) @(posedge clk);

    $display("covered %0d frames: %0d fills, %0d shifts with zero shutter, %0d results checked",
             frames_sent, fills_sent, zero_shutters, means_checked);
    $display("idling mixes: none, sender 83/100, receiver 83/100, both 31/100");
    if (mismatches == 0 && means_due == 0) begin
      $display("** sliding_trimmed_mean_filter: PASSED **");
    end else begin
      $display("** sliding_trimmed_mean_filter: FAILED **");
    end
    $finish;
  end

endmodule
